[src/cmed_pkg.sv]
// ----------------------------------------------------------------------------
// cmed_pkg
// Shared types and constants for the disk erode / dilate mask block:
// field widths, register map, command codes, control state and config bundle.
// ----------------------------------------------------------------------------
package cmed_pkg;

	// field widths
	localparam int DIM_W = 9;
	localparam int RAD_W = 4;
	localparam int IDX_W = 16;
	localparam int CMD_W = 2;

	// default store geometry
	localparam int DEF_MAX_WIDTH  = 256;
	localparam int DEF_MAX_HEIGHT = 256;
	localparam int DEF_MAX_RADIUS = 8;

	// configuration port
	localparam int CFG_AW = 4;
	localparam int CFG_DW = 32;

	// register reset values
	localparam logic [DIM_W-1:0] RST_FRAME_WIDTH  = DIM_W'(256);
	localparam logic [DIM_W-1:0] RST_FRAME_HEIGHT = DIM_W'(256);
	localparam logic [RAD_W-1:0] RST_DISK_RADIUS  = RAD_W'(1);
	localparam logic             RST_OP_MODE      = 1'b0;

	// register map, word index
	typedef enum logic [1:0] {
		REG_FRAME_WIDTH  = 2'd0,
		REG_FRAME_HEIGHT = 2'd1,
		REG_DISK_RADIUS  = 2'd2,
		REG_OP_MODE      = 2'd3
	} reg_idx_t;

	// command codes
	typedef enum logic [CMD_W-1:0] {
		CMD_WRITE = 2'd0,
		CMD_RUN   = 2'd1,
		CMD_READ  = 2'd2
	} cmd_t;

	// control sequencer
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_COPY_IN,
		ST_SCAN,
		ST_STAMP,
		ST_COPY_OUT,
		ST_FINISH
	} state_t;

	// configuration bundle
	typedef struct packed {
		logic [DIM_W-1:0] frame_width;
		logic [DIM_W-1:0] frame_height;
		logic [RAD_W-1:0] disk_radius;
		logic             op_mode;
	} cfg_t;

endpackage

[src/cmed_ram.sv]
// ----------------------------------------------------------------------------
// cmed_ram
// Generic single-write, single-read synchronous RAM with registered read data.
// ----------------------------------------------------------------------------
module cmed_ram #(
	parameter int WIDTH = 1,
	parameter int DEPTH = 2
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// read port, data held until the next read
	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

[src/cmed_regs.sv]
// ----------------------------------------------------------------------------
// cmed_regs
// APB-style configuration registers: frame size, disk radius and mode.
// ----------------------------------------------------------------------------
module cmed_regs (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [cmed_pkg::CFG_AW-1:0] paddr,
	input  logic [cmed_pkg::CFG_DW-1:0] pwdata,
	output logic [cmed_pkg::CFG_DW-1:0] prdata,
	output logic                        pready,
	output cmed_pkg::cfg_t              cfg
);
	import cmed_pkg::*;

	cfg_t     cfg_q;
	reg_idx_t reg_sel;
	logic     wr_en;

	assign pready  = 1'b1;
	assign reg_sel = reg_idx_t'(paddr[CFG_AW-1:2]);
	assign wr_en   = psel & penable & pwrite & pready;

	// register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.frame_width  <= RST_FRAME_WIDTH;
			cfg_q.frame_height <= RST_FRAME_HEIGHT;
			cfg_q.disk_radius  <= RST_DISK_RADIUS;
			cfg_q.op_mode      <= RST_OP_MODE;
		end else if (wr_en) begin
			case (reg_sel)
				REG_FRAME_WIDTH:  cfg_q.frame_width  <= pwdata[DIM_W-1:0];
				REG_FRAME_HEIGHT: cfg_q.frame_height <= pwdata[DIM_W-1:0];
				REG_DISK_RADIUS:  cfg_q.disk_radius  <= pwdata[RAD_W-1:0];
				REG_OP_MODE:      cfg_q.op_mode      <= pwdata[0];
				default: ;
			endcase
		end
	end

	// register readback
	always_comb begin
		case (reg_sel)
			REG_FRAME_WIDTH:  prdata = CFG_DW'(cfg_q.frame_width);
			REG_FRAME_HEIGHT: prdata = CFG_DW'(cfg_q.frame_height);
			REG_DISK_RADIUS:  prdata = CFG_DW'(cfg_q.disk_radius);
			REG_OP_MODE:      prdata = CFG_DW'(cfg_q.op_mode);
			default:          prdata = '0;
		endcase
	end

	assign cfg = cfg_q;

endmodule

[src/circular_mask_erode_dilate_top.sv]
// ----------------------------------------------------------------------------
// circular_mask_erode_dilate_top
// Disk-shaped binary erode / dilate over a one-bit mask frame held in a
// frame RAM, with a second RAM as scratch for the result of a run.
// ----------------------------------------------------------------------------
// Pixel writes and reads: one transfer per cycle while item_stall is low; the
//   result is registered in res_vld_s1, then in out_valid_q, the result_valid.
// Run: copy the frame into the result RAM, test the neighbors of each interior
//   pixel, stamp a disk around each border pixel, then copy the result back.
// Reset clears control and restores the register defaults; mask contents
//   stay undefined until written.
module circular_mask_erode_dilate_top #(
	parameter int MAX_WIDTH  = cmed_pkg::DEF_MAX_WIDTH,
	parameter int MAX_HEIGHT = cmed_pkg::DEF_MAX_HEIGHT,
	parameter int MAX_RADIUS = cmed_pkg::DEF_MAX_RADIUS
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [cmed_pkg::CFG_AW-1:0] paddr,
	input  logic [cmed_pkg::CFG_DW-1:0] pwdata,
	output logic [cmed_pkg::CFG_DW-1:0] prdata,
	output logic                        pready,
	input  logic                        item_valid,
	output logic                        item_stall,
	input  logic [cmed_pkg::CMD_W-1:0]  command,
	input  logic [cmed_pkg::IDX_W-1:0]  pixel_index,
	input  logic                        pixel_bit,
	output logic                        result_valid,
	input  logic                        result_stall,
	output logic                        read_bit,
	output logic                        run_done
);
	import cmed_pkg::*;

	localparam int DEPTH  = MAX_WIDTH * MAX_HEIGHT;
	localparam int AW     = $clog2(DEPTH);
	localparam int FS_W   = 2 * DIM_W;
	localparam int SPAN_W = RAD_W + 1;
	localparam int RW_W   = RAD_W + DIM_W;
	localparam int SQ_W   = 2 * RAD_W;

	// neighbor read order of the border test
	localparam logic [2:0] NB_C   = 3'd0;
	localparam logic [2:0] NB_L   = 3'd1;
	localparam logic [2:0] NB_R   = 3'd2;
	localparam logic [2:0] NB_U   = 3'd3;
	localparam logic [2:0] NB_D   = 3'd4;
	localparam logic [2:0] NB_END = 3'd5;

	cfg_t   cfg;
	cmd_t   cmd;
	state_t state_q, state_d;

	// effective settings
	logic [DIM_W-1:0]  eff_w, eff_h;
	logic [RAD_W-1:0]  eff_r;
	logic [SPAN_W-1:0] two_r;
	logic [FS_W-1:0]   fsize;
	logic              noop, in_range;

	// handshake
	logic ready, accept, out_free, s1_move;

	// run parameters
	logic [DIM_W-1:0]  w_q, xlast_q, ylast_q;
	logic [RAD_W-1:0]  r_q;
	logic [SPAN_W-1:0] span_q;
	logic [SQ_W-1:0]   rr_q;
	logic [RW_W-1:0]   rw_q;
	logic [AW-1:0]     last_q;
	logic              fill_q;

	// sweep and scan state
	logic [AW-1:0]     cnt_q, cur_q, srow_q, cp_addr_s1;
	logic              cp_vld_s1, cp_out_s1;
	logic [DIM_W-1:0]  x_q, y_q;
	logic [2:0]        nb_q, chk_nb_s1;
	logic              chk_vld_s1;
	logic [SPAN_W-1:0] sr_q, sc_q;

	// result path
	logic res_vld_s1, res_read_s1, res_run_s1;
	logic out_valid_q, read_bit_q, run_done_q;

	// derived control
	logic              cnt_last, pix_last, stamp_last;
	logic              decide_skip, decide_edge;
	logic [AW-1:0]     nb_addr, stamp_addr, cur_nx;
	logic [DIM_W-1:0]  x_nx, y_nx;
	logic [SPAN_W-1:0] dy_abs, dx_abs;
	logic [SQ_W-1:0]   dy_sq, dx_sq;
	logic [SQ_W:0]     sq_sum;
	logic              in_disk;

	// ram ports
	logic          a_we, a_re, b_we, b_re;
	logic [AW-1:0] a_waddr, a_raddr, b_waddr, b_raddr;
	logic [0:0]    a_wdata, a_rdata, b_wdata, b_rdata;

	cmed_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// frame store
	cmed_ram #(.WIDTH(1), .DEPTH(DEPTH)) u_frame_ram (
		.clk   (clk),
		.we    (a_we),
		.waddr (a_waddr),
		.wdata (a_wdata),
		.re    (a_re),
		.raddr (a_raddr),
		.rdata (a_rdata)
	);

	// result scratch store
	cmed_ram #(.WIDTH(1), .DEPTH(DEPTH)) u_result_ram (
		.clk   (clk),
		.we    (b_we),
		.waddr (b_waddr),
		.wdata (b_wdata),
		.re    (b_re),
		.raddr (b_raddr),
		.rdata (b_rdata)
	);

	assign cmd = cmd_t'(command);

	// clamp the configured geometry
	always_comb begin
		if (cfg.frame_width == '0) begin
			eff_w = DIM_W'(1);
		end else if (32'(cfg.frame_width) > MAX_WIDTH) begin
			eff_w = DIM_W'(MAX_WIDTH);
		end else begin
			eff_w = cfg.frame_width;
		end
		if (cfg.frame_height == '0) begin
			eff_h = DIM_W'(1);
		end else if (32'(cfg.frame_height) > MAX_HEIGHT) begin
			eff_h = DIM_W'(MAX_HEIGHT);
		end else begin
			eff_h = cfg.frame_height;
		end
		if (32'(cfg.disk_radius) > MAX_RADIUS) begin
			eff_r = RAD_W'(MAX_RADIUS);
		end else begin
			eff_r = cfg.disk_radius;
		end
	end

	assign two_r    = {eff_r, 1'b0};
	assign fsize    = FS_W'(eff_w) * FS_W'(eff_h);
	assign in_range = FS_W'(pixel_index) < fsize;
	assign noop     = (eff_r == '0) || (eff_w <= DIM_W'(two_r)) || (eff_h <= DIM_W'(two_r));

	// transfer control
	assign out_free   = !out_valid_q || !result_stall;
	assign s1_move    = res_vld_s1 && out_free;
	assign ready      = (state_q == ST_IDLE) && (!res_vld_s1 || out_free);
	assign accept     = item_valid && ready;
	assign item_stall = !ready;

	// sweep and scan conditions
	assign cnt_last    = cnt_q == last_q;
	assign pix_last    = (x_q == xlast_q) && (y_q == ylast_q);
	assign stamp_last  = (sr_q == span_q) && (sc_q == span_q);
	assign decide_skip = chk_vld_s1 && (((chk_nb_s1 == NB_C) && !a_rdata[0])
		|| ((chk_nb_s1 == NB_D) && a_rdata[0]));
	assign decide_edge = chk_vld_s1 && (chk_nb_s1 != NB_C) && !a_rdata[0];

	// neighbor address
	always_comb begin
		case (nb_q)
			NB_L:    nb_addr = cur_q - AW'(1);
			NB_R:    nb_addr = cur_q + AW'(1);
			NB_U:    nb_addr = cur_q - AW'(w_q);
			NB_D:    nb_addr = cur_q + AW'(w_q);
			default: nb_addr = cur_q;
		endcase
	end

	// next interior pixel
	always_comb begin
		if (x_q == xlast_q) begin
			x_nx   = DIM_W'(r_q);
			y_nx   = y_q + DIM_W'(1);
			cur_nx = cur_q + AW'(span_q) + AW'(1);
		end else begin
			x_nx   = x_q + DIM_W'(1);
			y_nx   = y_q;
			cur_nx = cur_q + AW'(1);
		end
	end

	// disk membership of the current stamp offset
	assign dy_abs     = (sr_q >= SPAN_W'(r_q)) ? sr_q - SPAN_W'(r_q) : SPAN_W'(r_q) - sr_q;
	assign dx_abs     = (sc_q >= SPAN_W'(r_q)) ? sc_q - SPAN_W'(r_q) : SPAN_W'(r_q) - sc_q;
	assign dy_sq      = SQ_W'(dy_abs[RAD_W-1:0]) * SQ_W'(dy_abs[RAD_W-1:0]);
	assign dx_sq      = SQ_W'(dx_abs[RAD_W-1:0]) * SQ_W'(dx_abs[RAD_W-1:0]);
	assign sq_sum     = (SQ_W+1)'(dy_sq) + (SQ_W+1)'(dx_sq);
	assign in_disk    = sq_sum <= (SQ_W+1)'(rr_q);
	assign stamp_addr = srow_q + AW'(sc_q);

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (accept && (cmd == CMD_RUN)) begin
					state_d = noop ? ST_FINISH : ST_COPY_IN;
				end
			end
			ST_COPY_IN: begin
				if (cnt_last) begin
					state_d = ST_SCAN;
				end
			end
			ST_SCAN: begin
				if (decide_edge) begin
					state_d = ST_STAMP;
				end else if (decide_skip && pix_last) begin
					state_d = ST_COPY_OUT;
				end
			end
			ST_STAMP: begin
				if (stamp_last) begin
					state_d = pix_last ? ST_COPY_OUT : ST_SCAN;
				end
			end
			ST_COPY_OUT: begin
				if (cnt_last) begin
					state_d = ST_FINISH;
				end
			end
			ST_FINISH: state_d = ST_IDLE;
			default:   state_d = ST_IDLE;
		endcase
	end

	// memory port control
	always_comb begin
		a_we    = 1'b0;
		a_waddr = cp_addr_s1;
		a_wdata = b_rdata;
		a_re    = 1'b0;
		a_raddr = cnt_q;
		b_we    = 1'b0;
		b_waddr = cp_addr_s1;
		b_wdata = a_rdata;
		b_re    = 1'b0;
		b_raddr = cnt_q;
		// trailing write of a copy sweep
		if (cp_vld_s1) begin
			if (cp_out_s1) begin
				a_we = 1'b1;
			end else begin
				b_we = 1'b1;
			end
		end
		case (state_q)
			ST_IDLE: begin
				if (accept && in_range) begin
					a_waddr = AW'(pixel_index);
					a_wdata = pixel_bit;
					a_raddr = AW'(pixel_index);
					a_we    = cmd == CMD_WRITE;
					a_re    = cmd == CMD_READ;
				end
			end
			ST_COPY_IN: a_re = 1'b1;
			ST_SCAN: begin
				a_re    = nb_q != NB_END;
				a_raddr = nb_addr;
			end
			ST_STAMP: begin
				b_we    = in_disk;
				b_waddr = stamp_addr;
				b_wdata = fill_q;
			end
			ST_COPY_OUT: b_re = 1'b1;
			default: ;
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			res_vld_s1  <= 1'b0;
			out_valid_q <= 1'b0;
			cp_vld_s1   <= 1'b0;
			chk_vld_s1  <= 1'b0;
		end else begin
			state_q   <= state_d;
			cp_vld_s1 <= (state_q == ST_COPY_IN) || (state_q == ST_COPY_OUT);
			// result stage
			if (accept) begin
				res_vld_s1 <= cmd != CMD_RUN;
			end else if (state_q == ST_FINISH) begin
				res_vld_s1 <= 1'b1;
			end else if (s1_move) begin
				res_vld_s1 <= 1'b0;
			end
			if (out_free) begin
				out_valid_q <= res_vld_s1;
			end
			// border test read in flight
			if ((state_q == ST_SCAN) && !decide_skip && !decide_edge) begin
				chk_vld_s1 <= nb_q != NB_END;
			end else begin
				chk_vld_s1 <= 1'b0;
			end
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		if (accept) begin
			res_read_s1 <= (cmd == CMD_READ) && in_range;
			res_run_s1  <= 1'b0;
		end else if (state_q == ST_FINISH) begin
			res_read_s1 <= 1'b0;
			res_run_s1  <= 1'b1;
		end
		if (out_free) begin
			read_bit_q <= res_read_s1 & a_rdata[0];
			run_done_q <= res_run_s1;
		end
	end

	// run parameters captured with the run command
	always_ff @(posedge clk) begin
		if (accept && (cmd == CMD_RUN)) begin
			w_q     <= eff_w;
			r_q     <= eff_r;
			span_q  <= two_r;
			rr_q    <= SQ_W'(eff_r) * SQ_W'(eff_r);
			rw_q    <= RW_W'(eff_r) * RW_W'(eff_w);
			xlast_q <= eff_w - DIM_W'(eff_r) - DIM_W'(1);
			ylast_q <= eff_h - DIM_W'(eff_r) - DIM_W'(1);
			last_q  <= AW'(fsize - FS_W'(1));
			fill_q  <= cfg.op_mode;
		end
	end

	// copy sweeps
	always_ff @(posedge clk) begin
		if (state_d != state_q) begin
			cnt_q <= '0;
		end else begin
			cnt_q <= cnt_q + AW'(1);
		end
		cp_addr_s1 <= cnt_q;
		cp_out_s1  <= state_q == ST_COPY_OUT;
	end

	// pixel scan and disk stamp
	always_ff @(posedge clk) begin
		case (state_q)
			ST_COPY_IN: begin
				cur_q <= AW'(rw_q) + AW'(r_q);
				x_q   <= DIM_W'(r_q);
				y_q   <= DIM_W'(r_q);
				nb_q  <= NB_C;
			end
			ST_SCAN: begin
				chk_nb_s1 <= nb_q;
				if (decide_skip || decide_edge) begin
					nb_q <= NB_C;
				end else if (nb_q != NB_END) begin
					nb_q <= nb_q + 3'd1;
				end
				if (decide_skip) begin
					x_q   <= x_nx;
					y_q   <= y_nx;
					cur_q <= cur_nx;
				end
				if (decide_edge) begin
					srow_q <= cur_q - AW'(rw_q) - AW'(r_q);
					sr_q   <= '0;
					sc_q   <= '0;
				end
			end
			ST_STAMP: begin
				if (sc_q == span_q) begin
					sc_q   <= '0;
					sr_q   <= sr_q + SPAN_W'(1);
					srow_q <= srow_q + AW'(w_q);
				end else begin
					sc_q <= sc_q + SPAN_W'(1);
				end
				if (stamp_last) begin
					x_q   <= x_nx;
					y_q   <= y_nx;
					cur_q <= cur_nx;
				end
			end
			default: ;
		endcase
	end

	// result port
	assign result_valid = out_valid_q;
	assign read_bit     = read_bit_q;
	assign run_done     = run_done_q;

endmodule

[tb/tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the disk erode / dilate mask block. Pixel writes,
// reads, runs and unknown commands go in through the item channel, mostly under
// random idling on both sides. A behavioral mirror of the frame predicts each result.
// The frame geometry, radius and mode are reprogrammed over the config port
// between phases, including out-of-range and saturating values.
// ----------------------------------------------------------------------------
module tb;
	import cmed_pkg::*;

	localparam int FRAME_DEPTH = DEF_MAX_WIDTH * DEF_MAX_HEIGHT;
	localparam logic [CMD_W-1:0] CMD_NONE = 2'd3;
	localparam int PRINT_CAP = 40;

	typedef struct packed {
		logic [CMD_W-1:0] code;
		logic [IDX_W-1:0] index;
		logic             value;
	} mask_op_t;

	typedef struct packed {
		logic read_bit;
		logic run_done;
	} mask_result_t;

	// block ports
	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              psel = 1'b0;
	logic              penable = 1'b0;
	logic              pwrite = 1'b0;
	logic [CFG_AW-1:0] paddr = '0;
	logic [CFG_DW-1:0] pwdata = '0;
	logic [CFG_DW-1:0] prdata;
	logic              pready;
	logic              item_valid = 1'b0;
	logic              item_stall;
	logic [CMD_W-1:0]  command = '0;
	logic [IDX_W-1:0]  pixel_index = '0;
	logic              pixel_bit = 1'b0;
	logic              result_valid;
	logic              result_stall = 1'b0;
	logic              read_bit;
	logic              run_done;

	// mirror of the register file
	logic [DIM_W-1:0] cfg_width = RST_FRAME_WIDTH;
	logic [DIM_W-1:0] cfg_height = RST_FRAME_HEIGHT;
	logic [RAD_W-1:0] cfg_radius = RST_DISK_RADIUS;
	logic             cfg_mode = RST_OP_MODE;

	// mirror of the frame and the run scratch
	bit frame_bits [FRAME_DEPTH];
	bit next_bits [FRAME_DEPTH];

	mask_op_t     pending_ops [$];
	mask_result_t awaited_results [$];

	int send_idle_pct = 26;
	int recv_idle_pct = 75;
	int mismatch_count = 0;
	int ops_accepted = 0;
	int results_checked = 0;
	int runs_predicted = 0;
	int reads_predicted = 0;
	int settings_used = 1;

	circular_mask_erode_dilate_top uut (
		.clk          (clk),
		.arst_n       (arst_n),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.prdata       (prdata),
		.pready       (pready),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.command      (command),
		.pixel_index  (pixel_index),
		.pixel_bit    (pixel_bit),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.read_bit     (read_bit),
		.run_done     (run_done)
	);

	// 20 ns clock
	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	task automatic report_mismatch(input string what);
		if (mismatch_count < PRINT_CAP)
			$display("mismatch at %0t: %s", $time, what);
		mismatch_count++;
	endtask

	// frame geometry after clamping, as the block sees it
	function automatic int unsigned frame_cols();
		if (cfg_width == 0) return 1;
		if (cfg_width > DEF_MAX_WIDTH) return DEF_MAX_WIDTH;
		return cfg_width;
	endfunction

	function automatic int unsigned frame_rows();
		if (cfg_height == 0) return 1;
		if (cfg_height > DEF_MAX_HEIGHT) return DEF_MAX_HEIGHT;
		return cfg_height;
	endfunction

	// stamp a disk around every border pixel of the interior margin
	function automatic void apply_disk_morph();
		int w, h, r, x, y, dx, dy, i;
		w = frame_cols();
		h = frame_rows();
		r = (cfg_radius > DEF_MAX_RADIUS) ? DEF_MAX_RADIUS : cfg_radius;
		for (i = 0; i < w * h; i++)
			next_bits[i] = frame_bits[i];
		if (r >= 1 && w > 2 * r && h > 2 * r) begin
			for (y = r; y < h - r; y++)
				for (x = r; x < w - r; x++) begin
					i = y * w + x;
					// border tests look at the frame as it was before the run
					if (frame_bits[i] && !(frame_bits[i-1] && frame_bits[i+1] &&
							frame_bits[i-w] && frame_bits[i+w])) begin
						for (dy = -r; dy <= r; dy++)
							for (dx = -r; dx <= r; dx++)
								if (dx * dx + dy * dy <= r * r)
									next_bits[(y + dy) * w + x + dx] = cfg_mode;
					end
				end
		end
		for (i = 0; i < w * h; i++)
			frame_bits[i] = next_bits[i];
	endfunction

	// expected result of one accepted transfer
	function automatic void predict_mask_op(input logic [CMD_W-1:0] code,
			input logic [IDX_W-1:0] index, input logic value);
		mask_result_t res;
		int unsigned pixels;
		res = '0;
		pixels = frame_cols() * frame_rows();
		case (code)
			CMD_WRITE: begin
				if (index < pixels)
					frame_bits[index] = value;
			end
			CMD_RUN: begin
				apply_disk_morph();
				res.run_done = 1'b1;
				runs_predicted++;
			end
			CMD_READ: begin
				if (index < pixels)
					res.read_bit = frame_bits[index];
				reads_predicted++;
			end
			default: ;
		endcase
		awaited_results.push_back(res);
	endfunction

	// item driver: advances on every transfer or empty slot
	always @(posedge clk) begin : drive_ops
		mask_op_t next_op;
		if (!arst_n) begin
			item_valid <= 1'b0;
		end else if (!item_valid || !item_stall) begin
			if (item_valid) begin
				predict_mask_op(command, pixel_index, pixel_bit);
				ops_accepted++;
			end
			if (pending_ops.size() > 0 && $urandom_range(99, 0) >= send_idle_pct) begin
				next_op = pending_ops.pop_front();
				command <= next_op.code;
				pixel_index <= next_op.index;
				pixel_bit <= next_op.value;
				item_valid <= 1'b1;
			end else begin
				item_valid <= 1'b0;
			end
		end
	end

	// result monitor and random receiver stall
	always @(posedge clk) begin : check_results
		mask_result_t want;
		if (!arst_n) begin
			result_stall <= 1'b0;
		end else begin
			if (result_valid && !result_stall) begin
				if (awaited_results.size() == 0) begin
					report_mismatch("result transfer with nothing awaited");
				end else begin
					want = awaited_results.pop_front();
					if (read_bit !== want.read_bit)
						report_mismatch($sformatf("read_bit %b, predicted %b",
							read_bit, want.read_bit));
					if (run_done !== want.run_done)
						report_mismatch($sformatf("run_done %b, predicted %b",
							run_done, want.run_done));
					results_checked++;
				end
			end
			result_stall <= ($urandom_range(99, 0) < recv_idle_pct);
		end
	end

	// run limit
	initial begin
		#50ms;
		$display("run limit reached with %0d results outstanding", awaited_results.size());
		$display("TB_ERROR");
		$finish;
	end

	task automatic queue_op(input logic [CMD_W-1:0] code, input int unsigned index,
			input logic value);
		mask_op_t op;
		op.code = code;
		op.index = IDX_W'(index);
		op.value = value;
		pending_ops.push_back(op);
	endtask

	// config write: setup cycle, then access cycle until pready
	task automatic write_reg(input reg_idx_t which, input logic [CFG_DW-1:0] value);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= CFG_AW'(4 * which);
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		case (which)
			REG_FRAME_WIDTH:  cfg_width = value[DIM_W-1:0];
			REG_FRAME_HEIGHT: cfg_height = value[DIM_W-1:0];
			REG_DISK_RADIUS:  cfg_radius = value[RAD_W-1:0];
			REG_OP_MODE:      cfg_mode = value[0];
			default: ;
		endcase
	endtask

	// program all registers, with junk above each field
	task automatic set_frame(input int w, input int h, input int r, input int mode);
		logic [CFG_DW-1:0] value;
		value = $urandom;
		value[DIM_W-1:0] = DIM_W'(w);
		write_reg(REG_FRAME_WIDTH, value);
		value = $urandom;
		value[DIM_W-1:0] = DIM_W'(h);
		write_reg(REG_FRAME_HEIGHT, value);
		value = $urandom;
		value[RAD_W-1:0] = RAD_W'(r);
		write_reg(REG_DISK_RADIUS, value);
		value = $urandom;
		value[0] = mode[0];
		write_reg(REG_OP_MODE, value);
		settings_used++;
	endtask

	// block until every transfer is in and every result is back
	task automatic wait_idle();
		do @(negedge clk);
		while (pending_ops.size() > 0 || item_valid || awaited_results.size() > 0);
		repeat (8) @(negedge clk);
	endtask

	task automatic set_idle(input int phase);
		if (phase <= 5) begin
			send_idle_pct = 26;
			recv_idle_pct = 75;
		end else if (phase <= 10) begin
			send_idle_pct = 75;
			recv_idle_pct = 26;
		end else begin
			send_idle_pct = 0;
			recv_idle_pct = 0;
		end
	endtask

	// mixed traffic once the whole frame holds known pixels
	task automatic queue_random_op(input int unsigned pixels);
		int roll;
		roll = $urandom_range(99, 0);
		if (roll < 40)
			queue_op(CMD_WRITE, $urandom_range(pixels - 1, 0), 1'($urandom_range(1, 0)));
		else if (roll < 65)
			queue_op(CMD_READ, $urandom_range(pixels - 1, 0), 1'($urandom_range(1, 0)));
		else if (roll < 75)
			queue_op(CMD_RUN, $urandom_range(FRAME_DEPTH - 1, 0), 1'($urandom_range(1, 0)));
		else if (roll < 85)
			queue_op(CMD_WRITE, $urandom_range(FRAME_DEPTH - 1, pixels),
				1'($urandom_range(1, 0)));
		else if (roll < 93)
			queue_op(CMD_READ, $urandom_range(FRAME_DEPTH - 1, pixels),
				1'($urandom_range(1, 0)));
		else
			queue_op(CMD_NONE, $urandom_range(FRAME_DEPTH - 1, 0), 1'($urandom_range(1, 0)));
	endtask

	// one frame setting: program, fill, run, then random traffic
	task automatic run_phase(input int phase, input int w, input int h, input int r,
			input int mode, input int count);
		int unsigned pixels;
		int density, i;
		set_idle(phase);
		set_frame(w, h, r, mode);
		pixels = frame_cols() * frame_rows();
		density = $urandom_range(90, 35);
		for (i = 0; i < pixels; i++)
			queue_op(CMD_WRITE, i, ($urandom_range(99, 0) < density));
		queue_op(CMD_RUN, 0, 1'b0);
		for (i = 0; i < 3; i++)
			queue_op(CMD_READ, $urandom_range(pixels - 1, 0), 1'b0);
		for (i = 0; i < count; i++)
			queue_random_op(pixels);
		wait_idle();
	endtask

	initial begin : stimulus
		int unsigned touched [$];
		int unsigned idx;
		int i, phase, r;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		repeat (2) @(negedge clk);

		// reset geometry: extreme indices, overwrite, unknown command
		set_idle(0);
		queue_op(CMD_WRITE, 0, 1'b1);
		queue_op(CMD_WRITE, FRAME_DEPTH - 1, 1'b1);
		queue_op(CMD_WRITE, 16'h5555, 1'b0);
		queue_op(CMD_WRITE, 16'hAAAA, 1'b1);
		queue_op(CMD_WRITE, 255, 1'b0);
		queue_op(CMD_WRITE, 256, 1'b1);
		queue_op(CMD_READ, 0, 1'b0);
		queue_op(CMD_READ, FRAME_DEPTH - 1, 1'b1);
		queue_op(CMD_READ, 16'h5555, 1'b1);
		queue_op(CMD_READ, 16'hAAAA, 1'b0);
		queue_op(CMD_READ, 255, 1'b0);
		queue_op(CMD_READ, 256, 1'b0);
		queue_op(CMD_NONE, FRAME_DEPTH - 1, 1'b1);
		queue_op(CMD_NONE, 0, 1'b0);
		queue_op(CMD_WRITE, 0, 1'b0);
		queue_op(CMD_READ, 0, 1'b0);
		queue_op(CMD_WRITE, 1000, 1'b1);
		queue_op(CMD_READ, 1000, 1'b0);
		queue_op(CMD_WRITE, 1000, 1'b0);
		queue_op(CMD_READ, 1000, 1'b0);
		touched = '{0, FRAME_DEPTH - 1, 16'h5555, 16'hAAAA, 255, 256, 1000};
		for (i = 0; i < 40; i++) begin
			if ($urandom_range(99, 0) < 50) begin
				idx = $urandom_range(FRAME_DEPTH - 1, 0);
				touched.push_back(idx);
				queue_op(CMD_WRITE, idx, 1'($urandom_range(1, 0)));
			end else if ($urandom_range(99, 0) < 85) begin
				queue_op(CMD_READ, touched[$urandom_range(touched.size() - 1, 0)], 1'b0);
			end else begin
				queue_op(CMD_NONE, $urandom_range(FRAME_DEPTH - 1, 0), 1'($urandom_range(1, 0)));
			end
		end
		wait_idle();

		// zero and oversized geometry, radius zero, frames too small to stamp
		run_phase(1, 511, 0, 1, 0, 6);
		run_phase(2, 0, 40, 0, 1, 8);
		run_phase(3, 12, 3, 1, 1, 10);
		run_phase(4, 3, 12, 1, 0, 10);
		run_phase(5, 8, 6, 1, 0, 16);
		run_phase(6, 7, 6, 2, 1, 12);
		// oversized radius saturates and still stamps
		run_phase(7, 17, 17, 15, 0, 8);
		run_phase(8, 7, 8, 3, 0, 12);
		run_phase(9, 6, 6, 3, 1, 8);
		run_phase(10, 3, 3, 1, 0, 12);
		// small random frames, mostly small radii
		for (phase = 11; phase < 13; phase++) begin
			r = ($urandom_range(99, 0) < 70) ? $urandom_range(3, 1) : $urandom_range(15, 0);
			run_phase(phase, $urandom_range(8, 3), $urandom_range(8, 3), r,
				$urandom_range(1, 0), 20);
		end

		$display("%0d transfers in, %0d results checked (%0d runs, %0d reads)",
			ops_accepted, results_checked, runs_predicted, reads_predicted);
		$display("%0d frame settings, %0d mismatches", settings_used, mismatch_count);
		if (mismatch_count == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule

[circular_mask_erode_dilate_top.f]
src/cmed_pkg.sv
src/cmed_ram.sv
src/cmed_regs.sv
src/circular_mask_erode_dilate_top.sv
tb/tb.sv
